@@ rtl/afls_pkg.sv @@
// Package for the animation frame loop sequencer.
// Holds field widths, register and command codes, and the controller/datapath
// command and status types. It depends on nothing else.
package afls_pkg;

   // Field widths fixed by the interface.
   localparam int FRAME_INDEX_W = 14;
   localparam int ELAPSED_W     = 20;
   localparam int SECS_W        = 16;
   localparam int RATE_W        = 16;
   localparam int PRODUCT_W     = 32;
   localparam int FRAC_W        = 24;
   localparam int WHOLE_W       = PRODUCT_W + 1 - FRAC_W;
   localparam int CMD_W         = 2;
   localparam int START_W       = 14;
   localparam int LOOP_CFG_W    = 5;

   // Stream and register port widths.
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 40;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FRAME   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_FRAME    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_TOTAL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_FOREVER  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PING_PONG     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAY_REVERSE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_RATE    = 3'd6;

   // Input command codes.
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REWIND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEEK   = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_FIRST,
      OP_SEEK,
      OP_MUL,
      OP_SUM,
      OP_REWIND,
      OP_LEN,
      OP_CLAMP,
      OP_START_MOD,
      OP_MOD_DONE,
      OP_START_DIV,
      OP_EVAL,
      OP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd_code;
      logic             first_tick;
      logic             whole_zero;
      logic             finished;
      logic             over;
      logic             loop_forever;
      logic             div_done;
   } dp_status_type;

endpackage

@@ rtl/afls_div.sv @@
// Serial restoring divider for the animation frame loop sequencer.
// Produces one quotient bit per cycle; uses no package items.
module afls_div #(
   parameter int DVD_W = 21,
   parameter int DVS_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DVD_W);

   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]    quo_ff, quo_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DVS_W:0]      trial;
   logic [DVS_W:0]      diff;
   logic                fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DVS_W bits.
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/afls_ctrl.sv @@
// Controller state machine of the animation frame loop sequencer.
// Sequences datapath operations and owns both handshakes; uses afls_pkg.
module afls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output afls_pkg::dp_cmd_type    cmd,
   input  afls_pkg::dp_status_type status
);

   import afls_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MUL,
      S_SUM,
      S_LEN,
      S_CHECK,
      S_START_DIV,
      S_MOD_WAIT,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      out_valid_in = out_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.cmd_code)
               CMD_TICK: begin
                  if (status.first_tick) begin
                     cmd.op   = OP_FIRST;
                     state_in = S_LEN;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               CMD_REWIND: begin
                  cmd.op   = OP_REWIND;
                  state_in = S_FINISH;
               end
               CMD_SEEK: begin
                  cmd.op   = OP_SEEK;
                  state_in = S_LEN;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = status.whole_zero ? S_FINISH : S_LEN;
         end
         S_LEN: begin
            // An ended sequence ignores every advance.
            if (status.finished) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_LEN;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.over && status.loop_forever) begin
               cmd.op   = OP_START_MOD;
               state_in = S_MOD_WAIT;
            end else if (status.over) begin
               cmd.op   = OP_CLAMP;
               state_in = S_START_DIV;
            end else begin
               state_in = S_START_DIV;
            end
         end
         S_START_DIV: begin
            cmd.op   = OP_START_DIV;
            state_in = S_DIV_WAIT;
         end
         S_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_MOD_DONE;
               state_in = S_START_DIV;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_EVAL;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.op       = OP_LOAD_OUT;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

endmodule

@@ rtl/afls_dp.sv @@
// Datapath of the animation frame loop sequencer: configuration registers,
// playback state, rate multiplier and frame evaluation. Uses afls_pkg, afls_div.
module afls_dp #(
   parameter int FRAME_BITS = 14,
   parameter int MAX_LOOPS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [afls_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [afls_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [afls_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [afls_pkg::CMD_W-1:0]           req_tuser,
   input  afls_pkg::dp_cmd_type                  cmd,
   output afls_pkg::dp_status_type               status,
   output logic [afls_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   import afls_pkg::*;

   localparam int SPAN_W  = FRAME_BITS + 1;
   localparam int LOOP_W  = $clog2(2 * MAX_LOOPS + 1);
   localparam int LEN_W   = SPAN_W + LOOP_W;
   localparam int SUM_W   = ELAPSED_W + 1;
   localparam int CMP_W   = (LEN_W > SUM_W) ? LEN_W : SUM_W;
   localparam int RSP_PAD = RSP_DATA_W - FRAME_INDEX_W - 2 - ELAPSED_W;

   // Configuration registers.
   logic [START_W-1:0]    start_ff, start_in;
   logic [START_W-1:0]    stop_ff, stop_in;
   logic [LOOP_CFG_W-1:0] loop_total_ff, loop_total_in;
   logic                  forever_ff, forever_in;
   logic                  ping_ff, ping_in;
   logic                  reverse_ff, reverse_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;

   // Playback state.
   logic [FRAME_BITS-1:0] current_ff, current_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic                  finished_ff, finished_in;
   logic                  first_ff, first_in;

   // Per-word working registers.
   logic [CMD_W-1:0]      code_ff, code_in;
   logic [SECS_W-1:0]     secs_ff, secs_in;
   logic [ELAPSED_W-1:0]  seek_ff, seek_in;
   logic [PRODUCT_W-1:0]  product_ff, product_in;
   logic [CMP_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] lo_ff, lo_in;
   logic [FRAME_BITS-1:0] hi_ff, hi_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic                  force_ff, force_in;
   logic                  upd_ff, upd_in;

   // Result word register.
   logic [FRAME_INDEX_W-1:0] out_frame_ff, out_frame_in;
   logic                     out_upd_ff, out_upd_in;
   logic                     out_ended_ff, out_ended_in;
   logic [ELAPSED_W-1:0]     out_elapsed_ff, out_elapsed_in;

   // Combinational helpers.
   logic [PRODUCT_W:0]    sum_w;
   logic [WHOLE_W-1:0]    whole;
   logic [FRAME_BITS-1:0] lo_c, hi_raw, hi_c;
   logic [SPAN_W-1:0]     span_c;
   logic [LOOP_W-1:0]     loops_base, loops_c;
   logic [LEN_W-1:0]      length_c;
   logic [FRAME_BITS-1:0] pos;
   logic                  rev;
   logic [FRAME_BITS-1:0] frame_c;

   // Divider connections.
   logic                  div_start;
   logic [LEN_W-1:0]      div_divisor;
   logic                  div_done;
   logic [CMP_W-1:0]      div_quo;
   logic [LEN_W-1:0]      div_rem;

   afls_div #(
      .DVD_W (CMP_W),
      .DVS_W (LEN_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (count_ff),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign div_start   = (cmd.op == OP_START_MOD) || (cmd.op == OP_START_DIV);
   assign div_divisor = (cmd.op == OP_START_MOD) ? length_ff : LEN_W'(span_ff);

   // Register writes.
   always_comb begin
      start_in      = start_ff;
      stop_in       = stop_ff;
      loop_total_in = loop_total_ff;
      forever_in    = forever_ff;
      ping_in       = ping_ff;
      reverse_in    = reverse_ff;
      rate_in       = rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_FRAME:  start_in      = csr_wdata[START_W-1:0];
            CSR_STOP_FRAME:   stop_in       = csr_wdata[START_W-1:0];
            CSR_LOOP_TOTAL:   loop_total_in = csr_wdata[LOOP_CFG_W-1:0];
            CSR_LOOP_FOREVER: forever_in    = csr_wdata[0];
            CSR_PING_PONG:    ping_in       = csr_wdata[0];
            CSR_PLAY_REVERSE: reverse_in    = csr_wdata[0];
            CSR_FRAME_RATE:   rate_in       = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Range, loop length and frame helpers.
   always_comb begin
      sum_w  = {1'b0, product_ff} + (PRODUCT_W + 1)'(frac_ff);
      whole  = sum_w[PRODUCT_W:FRAC_W];
      lo_c   = FRAME_BITS'(start_ff);
      hi_raw = FRAME_BITS'(stop_ff);
      hi_c   = (hi_raw < lo_c) ? lo_c : hi_raw;
      span_c = SPAN_W'(hi_c) - SPAN_W'(lo_c) + SPAN_W'(1);
      if (loop_total_ff == '0) begin
         loops_base = LOOP_W'(1);
      end else if (int'(loop_total_ff) > MAX_LOOPS) begin
         loops_base = LOOP_W'(MAX_LOOPS);
      end else begin
         loops_base = LOOP_W'(loop_total_ff);
      end
      loops_c  = ping_ff ? (loops_base << 1) : loops_base;
      length_c = LEN_W'(span_c) * LEN_W'(loops_c);
      // In ping-pong mode odd passes run against the play direction.
      pos     = div_rem[FRAME_BITS-1:0];
      rev     = reverse_ff ^ (ping_ff & div_quo[0]);
      frame_c = rev ? (hi_ff - pos) : (lo_ff + pos);
   end

   // Operation decode.
   always_comb begin
      current_in     = current_ff;
      elapsed_in     = elapsed_ff;
      frac_in        = frac_ff;
      finished_in    = finished_ff;
      first_in       = first_ff;
      code_in        = code_ff;
      secs_in        = secs_ff;
      seek_in        = seek_ff;
      product_in     = product_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      span_in        = span_ff;
      length_in      = length_ff;
      force_in       = force_ff;
      upd_in         = upd_ff;
      out_frame_in   = out_frame_ff;
      out_upd_in     = out_upd_ff;
      out_ended_in   = out_ended_ff;
      out_elapsed_in = out_elapsed_ff;
      unique case (cmd.op)
         OP_LATCH: begin
            code_in  = req_tuser;
            secs_in  = req_tdata[SECS_W-1:0];
            seek_in  = req_tdata[SECS_W+ELAPSED_W-1:SECS_W];
            upd_in   = 1'b0;
            force_in = 1'b0;
         end
         OP_FIRST: begin
            first_in = 1'b0;
            count_in = '0;
            force_in = 1'b1;
         end
         OP_SEEK: count_in = CMP_W'(seek_ff);
         OP_MUL: product_in = PRODUCT_W'(secs_ff) * PRODUCT_W'(rate_ff);
         OP_SUM: begin
            frac_in  = sum_w[FRAC_W-1:0];
            count_in = CMP_W'(elapsed_ff) + CMP_W'(whole);
         end
         OP_REWIND: begin
            current_in  = '0;
            elapsed_in  = '0;
            frac_in     = '0;
            finished_in = 1'b0;
            first_in    = 1'b1;
         end
         OP_LEN: begin
            lo_in     = lo_c;
            hi_in     = hi_c;
            span_in   = span_c;
            length_in = length_c;
         end
         OP_CLAMP: begin
            count_in    = CMP_W'(length_ff) - CMP_W'(1);
            finished_in = 1'b1;
         end
         OP_MOD_DONE: count_in = CMP_W'(div_rem);
         OP_EVAL: begin
            elapsed_in = count_ff[ELAPSED_W-1:0];
            if (force_ff || (frame_c != current_ff)) begin
               current_in = frame_c;
               upd_in     = 1'b1;
            end
         end
         OP_LOAD_OUT: begin
            out_frame_in   = FRAME_INDEX_W'(current_ff);
            out_upd_in     = upd_ff;
            out_ended_in   = finished_ff;
            out_elapsed_in = elapsed_ff;
         end
         OP_START_MOD, OP_START_DIV, OP_NONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         stop_ff       <= '0;
         loop_total_ff <= LOOP_CFG_W'(1);
         forever_ff    <= 1'b0;
         ping_ff       <= 1'b0;
         reverse_ff    <= 1'b0;
         rate_ff       <= RATE_W'(7680);
         current_ff    <= '0;
         elapsed_ff    <= '0;
         frac_ff       <= '0;
         finished_ff   <= 1'b0;
         first_ff      <= 1'b1;
      end else begin
         start_ff      <= start_in;
         stop_ff       <= stop_in;
         loop_total_ff <= loop_total_in;
         forever_ff    <= forever_in;
         ping_ff       <= ping_in;
         reverse_ff    <= reverse_in;
         rate_ff       <= rate_in;
         current_ff    <= current_in;
         elapsed_ff    <= elapsed_in;
         frac_ff       <= frac_in;
         finished_ff   <= finished_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      secs_ff        <= secs_in;
      seek_ff        <= seek_in;
      product_ff     <= product_in;
      count_ff       <= count_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      span_ff        <= span_in;
      length_ff      <= length_in;
      force_ff       <= force_in;
      upd_ff         <= upd_in;
      out_frame_ff   <= out_frame_in;
      out_upd_ff     <= out_upd_in;
      out_ended_ff   <= out_ended_in;
      out_elapsed_ff <= out_elapsed_in;
   end

   assign status.cmd_code     = code_ff;
   assign status.first_tick   = first_ff;
   assign status.whole_zero   = (whole == '0);
   assign status.finished     = finished_ff;
   assign status.over         = (count_ff >= CMP_W'(length_ff));
   assign status.loop_forever = forever_ff;
   assign status.div_done     = div_done;

   assign rsp_tdata = {{RSP_PAD{1'b0}}, out_elapsed_ff, out_ended_ff, out_upd_ff, out_frame_ff};

endmodule

@@ rtl/animation_frame_loop_sequencer.sv @@
// Top level of the animation frame loop sequencer.
// Joins the controller (afls_ctrl) and the datapath (afls_dp); uses afls_pkg.
//
// The block turns a stream of tick, rewind and seek words into frame indexes.
// A tick scales its elapsed time by frame_rate_q8, adds it to a 24-bit
// fraction accumulator and advances the elapsed frame count by the whole
// frames. The count wraps inside span times loops (doubled in ping-pong mode)
// or, for a finite sequence, clamps to the last frame and sets ended. The
// first tick after reset or rewind forces the first frame of the pass and
// ignores time. Each request word gives exactly one response word. Items are
// handled one at a time: a tick that reaches frame evaluation is latched,
// decoded, scaled, summed, checked against the loop length and divided by
// the span; a seek skips the scaling and the sum, and a wrap of an endless
// loop adds a second division by the loop length first. Rewind, unused
// codes, ticks worth no whole frame and words after the sequence ended skip
// the division. The shared serial divider retires one quotient bit per
// cycle. A finished response waits in an output register, so the next
// request word is accepted while the previous response is not yet taken.
// Registers are to be written through the csr port only while the block is
// idle; the block itself does not enforce this. They have no read-back.
module animation_frame_loop_sequencer #(
   parameter int FRAME_BITS = 14,
   parameter int MAX_LOOPS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Register write port.
   input  logic                              csr_we,
   input  logic [afls_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [afls_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tick_seconds [15:0], seek_count [35:16], zeros [39:36]
   input  logic [afls_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command [1:0]
   input  logic [afls_pkg::CMD_W-1:0]        req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame number [13:0], frame_update [14], ended [15], elapsed_count [35:16],
   // zeros [39:36]
   output logic [afls_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import afls_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller owns both handshakes and steps the datapath one operation
   // per cycle, pausing while the divider runs or the response register is not taken.
   afls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

   // The datapath holds the registers, the playback state, the result word
   // and the serial divider.
   afls_dp #(
      .FRAME_BITS (FRAME_BITS),
      .MAX_LOOPS  (MAX_LOOPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ rtl/afls_checker.sv @@
// Port-level checker for the animation frame loop sequencer and its bind.
// Uses afls_pkg; attaches to animation_frame_loop_sequencer.
module afls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [afls_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import afls_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // Words accepted whose responses are not yet taken.
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed or dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("request accepted while the previous word is in work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response word without an accepted request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 2'd2)
      else $error("more than two words in flight");

endmodule

bind animation_frame_loop_sequencer afls_checker u_checker (.*);

@@ tb/animation_frame_loop_sequencer_tb.sv @@
// Self-checking testbench for animation_frame_loop_sequencer: tick, rewind and seek
// words go in on the request stream and every response word is checked against a
// frame timing predictor kept in this file. Depends on afls_pkg and the block only.
`timescale 1ns / 1ps

module animation_frame_loop_sequencer_tb;

   import afls_pkg::*;

   // The block ignores command code 3; the package only names the three it uses.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Loop count saturation of the default build.
   localparam int unsigned LOOP_LIMIT = 16;

   localparam int SETTLE_CYCLES = 64;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_WORDS  = 1950;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [SECS_W-1:0]    secs;
      logic [ELAPSED_W-1:0] seek;
   } anim_word_type;

   typedef struct packed {
      logic [FRAME_INDEX_W-1:0] frame_num;
      logic                     frame_update;
      logic                     ended;
      logic [ELAPSED_W-1:0]     elapsed_count;
   } frame_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_LUMPY
   } ready_style_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [CMD_W-1:0]        req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   animation_frame_loop_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words waiting to be offered, and the responses that accepted words owe.
   anim_word_type    pending_words[$];
   frame_result_type owed_frames[$];
   int unsigned      fail_count = 0;

   // Knobs the stimulus process turns between phases.
   bit               sender_bursty = 1'b1;
   ready_style_type  ready_style = READY_RANDOM;
   bit               long_hold_request = 1'b0;

   // Register mirror, kept in step with every csr write.
   logic [START_W-1:0]    cfg_start = '0;
   logic [START_W-1:0]    cfg_stop = '0;
   logic [LOOP_CFG_W-1:0] cfg_loops = 5'd1;
   logic                  cfg_forever = 1'b0;
   logic                  cfg_ping_pong = 1'b0;
   logic                  cfg_reverse = 1'b0;
   logic [RATE_W-1:0]     cfg_rate = 16'd7680;

   // Predicted sequencer state, matching the block's reset values.
   logic [FRAME_INDEX_W-1:0] shown_frame = '0;
   logic [ELAPSED_W-1:0]     play_count = '0;
   logic [FRAC_W-1:0]        frame_frac = '0;
   logic                     seq_ended = 1'b0;
   logic                     await_first_tick = 1'b1;

   // Places an absolute elapsed count inside the played range and works out the
   // frame it lands on. Returns whether the frame has to be redrawn.
   function automatic logic place_count(input logic forced, input int unsigned count);
      int unsigned lo, hi, span, loops, length, pass_no, pos, frame;
      logic        backward;
      if (seq_ended)
         return 1'b0;
      lo = cfg_start;
      hi = cfg_stop;
      // A stop frame below the start frame collapses the range to one frame.
      if (hi < lo)
         hi = lo;
      span = hi - lo + 1;
      loops = cfg_loops;
      if (loops < 1)
         loops = 1;
      if (loops > LOOP_LIMIT)
         loops = LOOP_LIMIT;
      if (cfg_ping_pong)
         loops = loops * 2;
      length = span * loops;
      if (count >= length) begin
         if (cfg_forever) begin
            count = count % length;
         end else begin
            count = length - 1;
            seq_ended = 1'b1;
         end
      end
      play_count = count[ELAPSED_W-1:0];
      pass_no = count / span;
      pos = count % span;
      // Ping-pong turns the direction around on every odd pass.
      backward = cfg_reverse ^ (cfg_ping_pong & pass_no[0]);
      frame = backward ? hi - pos : lo + pos;
      if (forced || frame[FRAME_INDEX_W-1:0] != shown_frame) begin
         shown_frame = frame[FRAME_INDEX_W-1:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the predicted state by one accepted word and returns its response.
   function automatic frame_result_type frame_after_word(input anim_word_type w);
      frame_result_type  res;
      logic              redraw;
      logic [47:0]       scaled;
      logic [23:0]       whole;
      redraw = 1'b0;
      case (w.command)
         CMD_TICK: begin
            if (await_first_tick) begin
               // The first tick shows the start of the sequence and ignores time.
               await_first_tick = 1'b0;
               redraw = place_count(1'b1, 0);
            end else begin
               scaled = 48'(w.secs) * 48'(cfg_rate) + 48'(frame_frac);
               whole = scaled[47:24];
               frame_frac = scaled[23:0];
               if (whole != 0)
                  redraw = place_count(1'b0, 32'(play_count) + 32'(whole));
            end
         end
         CMD_REWIND: begin
            shown_frame = '0;
            play_count = '0;
            frame_frac = '0;
            seq_ended = 1'b0;
            await_first_tick = 1'b1;
         end
         CMD_SEEK: begin
            redraw = place_count(1'b0, 32'(w.seek));
         end
         default: begin
         end
      endcase
      res.frame_num = shown_frame;
      res.frame_update = redraw;
      res.ended = seq_ended;
      res.elapsed_count = play_count;
      return res;
   endfunction

   // Request side. A word counts as accepted on the rising edge where tvalid and
   // tready meet; its expected response is worked out right there, so register
   // writes between phases reach the predictor in the same order as the block.
   bit req_word_taken = 1'b0;

   always @(posedge clock) begin : req_accept
      anim_word_type w;
      req_word_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         w = pending_words.pop_front();
         owed_frames.push_back(frame_after_word(w));
         req_word_taken = 1'b1;
      end
   end

   // The sender offers words in bursts. A word that is on the bus and not yet
   // taken is held as it is; gaps only open between words.
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_word_taken) begin
         // Still waiting for the block to take the current word.
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= {4'h0, pending_words[0].seek, pending_words[0].secs};
         req_tuser <= pending_words[0].command;
         if (burst_left != 0)
            burst_left = burst_left - 1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = sender_bursty ? $urandom_range(1, 12) : 0;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response side. The stall style changes per phase; on request the receiver
   // also holds off for a long stretch so that the block backs up into its input.
   int unsigned hold_left = 0;
   int unsigned pattern_step = 0;
   int unsigned lump_left = 0;

   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_request) begin
            hold_left = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         pattern_step = (pattern_step + 1) % 11;
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
               READY_PATTERN: rsp_tready <= (pattern_step > 2);
               default: begin
                  // Mostly ready, now and then a stall of random length.
                  if (lump_left != 0) begin
                     lump_left = lump_left - 1;
                     rsp_tready <= 1'b0;
                  end else if ($urandom_range(0, 15) == 0) begin
                     lump_left = $urandom_range(1, 12);
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Every response word is matched against the oldest owed result.
   always @(posedge clock) begin : rsp_monitor
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_frames.size() == 0) begin
            $error("response word with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = owed_frames.pop_front();
            if (rsp_tdata[13:0] !== want.frame_num) begin
               $error("frame_num: expected %0d, got %0d", want.frame_num,
                      rsp_tdata[13:0]);
               fail_count++;
            end
            if (rsp_tdata[14] !== want.frame_update) begin
               $error("frame_update: expected %0d, got %0d", want.frame_update,
                      rsp_tdata[14]);
               fail_count++;
            end
            if (rsp_tdata[15] !== want.ended) begin
               $error("ended: expected %0d, got %0d", want.ended, rsp_tdata[15]);
               fail_count++;
            end
            if (rsp_tdata[35:16] !== want.elapsed_count) begin
               $error("elapsed_count: expected %0d, got %0d", want.elapsed_count,
                      rsp_tdata[35:16]);
               fail_count++;
            end
         end
      end
   end

   // One register write, mirrored into the predictor's copy at the same time.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (index)
         CSR_START_FRAME:  cfg_start = value[START_W-1:0];
         CSR_STOP_FRAME:   cfg_stop = value[START_W-1:0];
         CSR_LOOP_TOTAL:   cfg_loops = value[LOOP_CFG_W-1:0];
         CSR_LOOP_FOREVER: cfg_forever = value[0];
         CSR_PING_PONG:    cfg_ping_pong = value[0];
         CSR_PLAY_REVERSE: cfg_reverse = value[0];
         CSR_FRAME_RATE:   cfg_rate = value[RATE_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input int unsigned start_f, input int unsigned stop_f,
                                 input int unsigned loops, input int unsigned forever_f,
                                 input int unsigned ping_pong_f, input int unsigned reverse_f,
                                 input int unsigned rate);
      write_reg(CSR_START_FRAME, start_f);
      write_reg(CSR_STOP_FRAME, stop_f);
      write_reg(CSR_LOOP_TOTAL, loops);
      write_reg(CSR_LOOP_FOREVER, forever_f);
      write_reg(CSR_PING_PONG, ping_pong_f);
      write_reg(CSR_PLAY_REVERSE, reverse_f);
      write_reg(CSR_FRAME_RATE, rate);
   endtask

   // Random playback settings that lean toward short ranges but visit the edges:
   // single-frame and full ranges, a stop below the start, out-of-range loop counts and
   // the slowest and fastest rates.
   task automatic pick_settings;
      int unsigned s, e, l, r, pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         s = 0;
      else if (pick < 15)
         s = 16383;
      else if (pick < 75)
         s = $urandom_range(0, 200);
      else
         s = $urandom_range(0, 16383);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         e = s + $urandom_range(0, 15);
      else if (pick < 78)
         e = s + $urandom_range(16, 400);
      else if (pick < 86)
         e = 16383;
      else if (pick < 94)
         e = (s == 0) ? 0 : $urandom_range(0, s - 1);
      else
         e = $urandom_range(0, 16383);
      if (e > 16383)
         e = 16383;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         l = $urandom_range(1, 16);
      else if (pick < 80)
         l = 0;
      else if (pick < 90)
         l = 31;
      else
         l = $urandom_range(0, 31);
      pick = $urandom_range(0, 99);
      if (pick < 60)
         r = $urandom_range(16'h0800, 16'h7800);
      else if (pick < 70)
         r = 0;
      else if (pick < 80)
         r = 16'hFFFF;
      else
         r = $urandom_range(0, 16'hFFFF);
      apply_settings(s, e, l, $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), r);
   endtask

   task automatic queue_word(input logic [CMD_W-1:0] command, input int unsigned secs,
                             input int unsigned seek);
      anim_word_type w;
      w.command = command;
      w.secs = secs[SECS_W-1:0];
      w.seek = seek[ELAPSED_W-1:0];
      pending_words.push_back(w);
   endtask

   // Mostly ticks of short, tiny or random length, with seeks, rewinds that restart
   // finished sequences, and a few words of the unused code. The field that a
   // command does not use still carries random bits.
   task automatic queue_random_word;
      int unsigned pick, secs, seek;
      pick = $urandom_range(0, 99);
      secs = $urandom_range(0, 16'hFFFF);
      seek = $urandom() & 32'hFFFFF;
      if (pick < 70) begin
         case ($urandom_range(0, 2))
            0: secs = $urandom_range(16'h0100, 16'h0900);
            1: secs = $urandom_range(0, 16'h00FF);
            default: begin
            end
         endcase
         queue_word(CMD_TICK, secs, seek);
      end else if (pick < 82) begin
         if ($urandom_range(0, 1) == 0)
            seek = $urandom_range(0, 600);
         queue_word(CMD_SEEK, secs, seek);
      end else if (pick < 95) begin
         queue_word(CMD_REWIND, secs, seek);
      end else begin
         queue_word(CMD_UNUSED, secs, seek);
      end
   endtask

   // Waits until every word went in and every response came back, then lets
   // the block settle so that register writes find it idle.
   task automatic wait_drained;
      while (pending_words.size() != 0 || owed_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned queued;
      int unsigned phase_no;
      int unsigned phase_len;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: a five frame ping-pong range played twice, 20 counts long.
      apply_settings(2, 6, 2, 0, 1, 0, 16'h1E00);
      queue_word(CMD_TICK, 16'hFFFF, 20'hFFFFF);  // first tick, time ignored
      queue_word(CMD_TICK, 16'h0000, 0);          // no whole frame
      queue_word(CMD_TICK, 16'h0889, 0);          // exactly one frame
      queue_word(CMD_TICK, 16'hFFFF, 0);          // runs past the end, clamps
      queue_word(CMD_TICK, 16'h1000, 0);          // already ended
      queue_word(CMD_SEEK, 0, 5);                 // seek after the end
      queue_word(CMD_UNUSED, 16'hFFFF, 20'hFFFFF);
      queue_word(CMD_REWIND, 0, 0);
      queue_word(CMD_SEEK, 0, 7);                 // seek before the first tick
      queue_word(CMD_TICK, 16'h0000, 0);          // still forced to the start frame
      queue_word(CMD_SEEK, 0, 12);                // third pass, forward
      queue_word(CMD_SEEK, 0, 17);                // fourth pass lands on the same frame
      queue_word(CMD_SEEK, 0, 20'hFFFFF);         // widest count, clamps
      queue_word(CMD_REWIND, 0, 0);
      queue_word(CMD_TICK, 16'h1234, 0);
      queue_word(CMD_SEEK, 0, 0);
      wait_drained();

      // Stop below start, loop count zero, endless loop, reverse, fastest rate.
      apply_settings(16383, 0, 0, 1, 0, 1, 16'hFFFF);
      queue_word(CMD_REWIND, 0, 0);
      queue_word(CMD_TICK, 0, 0);
      queue_word(CMD_TICK, 16'hFFFF, 0);
      queue_word(CMD_SEEK, 0, 20'hFFFFF);
      wait_drained();

      // Full range, loop count past the limit, ping-pong, reverse, rate zero.
      apply_settings(0, 16383, 31, 0, 1, 1, 0);
      queue_word(CMD_REWIND, 0, 0);
      queue_word(CMD_TICK, 0, 0);
      queue_word(CMD_TICK, 16'hFFFF, 0);
      queue_word(CMD_SEEK, 0, 20'h80000);
      wait_drained();

      // Random phases, each with its own settings and its own idling.
      queued = 0;
      phase_no = 0;
      while (queued < RANDOM_WORDS) begin
         pick_settings();
         phase_len = $urandom_range(40, 160);
         sender_bursty = ($urandom_range(0, 2) != 0);
         ready_style = ready_style_type'($urandom_range(0, 3));
         if (phase_no % 8 == 1) begin
            // Keep offering words while the receiver sits still.
            sender_bursty = 1'b0;
            long_hold_request = 1'b1;
         end
         @(negedge clock);
         queue_word(CMD_REWIND, $urandom_range(0, 16'hFFFF), $urandom() & 32'hFFFFF);
         for (int i = 0; i < phase_len; i++)
            queue_random_word();
         queued += phase_len + 1;
         phase_no++;
         wait_drained();
      end

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // A timeout of several times the slowest correct run.
   initial begin : watchdog
      #(8_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
